// File: rtl/kli_pkg.sv
// Shared constants for the keyframe linear interpolator.
// No dependencies.
`timescale 1ns / 1ps
package kli_pkg;

  // command kinds carried on s_tuser
  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_SAVE = 2'd1;
  localparam logic [1:0] CMD_PLAY = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_STOP = 2'd2;

  // configuration register indexes
  localparam logic CFG_STEPS = 1'b0;
  localparam logic CFG_DRIFT = 1'b1;

  localparam int DRIFT_CH = 4;
  localparam int KEEP_A   = 3;
  localparam int KEEP_B   = 4;

  localparam logic [15:0] STEPS_RST = 16'd60;
  localparam logic [31:0] DRIFT_RST = 32'd6554;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

endpackage

// File: rtl/kli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module kli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 117
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/keyframe_linear_interpolator.sv
// Keyframe linear interpolator top level.
// Uses kli_pkg and one kli_ram for the keyframe table.
`timescale 1ns / 1ps
// One command beat at a time; s_tready is high only while the sequencer is idle.
// Save writes one keyframe RAM entry per channel. A Tick that interpolates does
// one saturating add per channel, then gives one result beat per channel. Play
// and a segment-advancing Tick recompute every increment through one shared
// restoring divider of 32 steps, after the two keyframe RAM reads for each
// channel, and then give their results. Output stalls on m_tready hold the
// sequencer until each result beat is taken.
module keyframe_linear_interpolator #(
  parameter int NUM_FRAMES   = 9,
  parameter int NUM_CHANNELS = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [kli_pkg::IN_TDATA_W-1:0]      s_tdata,  // channel[3:0], value[35:4], zero pad
  input  logic [1:0]                          s_tuser,  // cmd[1:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [kli_pkg::OUT_TDATA_W-1:0]     m_tdata,  // out_channel[3:0], out_value[35:4],
                                                        // status[37:36], playing[38], pad
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [31:0]                         cfg_data
);
  import kli_pkg::*;

  localparam int ChW   = $clog2(NUM_CHANNELS);
  localparam int FW    = $clog2(NUM_FRAMES + 1);
  localparam int Depth = NUM_FRAMES * NUM_CHANNELS;
  localparam int AW    = $clog2(Depth);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ONE  = 4'd1;
  localparam logic [3:0] S_SAVE = 4'd2;
  localparam logic [3:0] S_RDA  = 4'd3;
  localparam logic [3:0] S_RDB  = 4'd4;
  localparam logic [3:0] S_GETB = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_WRI  = 4'd7;
  localparam logic [3:0] S_ADD  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]      state;
  logic [15:0]     steps;
  logic [31:0]     drift;
  logic [31:0]     pose [NUM_CHANNELS];
  logic [31:0]     incr [NUM_CHANNELS];
  logic [FW-1:0]   frame_count;
  logic [FW-1:0]   segment;
  logic [15:0]     step_count;
  logic            running;
  logic            reload;
  logic            from_play;
  logic [ChW-1:0]  cnt;
  logic [3:0]      res_ch;
  logic [31:0]     res_val;
  logic [1:0]      res_st;
  logic [31:0]     kf_a;
  logic            neg;
  logic [31:0]     quo;
  logic [15:0]     rem;
  logic [4:0]      it;

  logic [3:0]      out_ch;
  logic [31:0]     out_val;
  logic [1:0]      out_st;
  logic            out_play;

  logic [15:0]     div_d;
  logic            out_free;
  logic            out_load;
  logic            in_beat;
  logic [3:0]      in_ch;
  logic [31:0]     in_val;
  logic [FW-1:0]   s1;
  logic [FW:0]     seg_n;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   ram_raddr;
  logic [31:0]     ram_q;
  logic [32:0]     diff;
  logic [16:0]     rem_sh;
  logic            rem_ge;
  logic [32:0]     qs;
  logic [33:0]     add_sum;
  logic [31:0]     add_sat;
  logic            is_last_ch;

  assign div_d      = (steps == 16'd0) ? 16'd1 : steps;
  assign out_free   = !m_tvalid || m_tready;
  assign out_load   = ((state == S_ONE) || (state == S_OUT)) && out_free;
  assign s_tready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_beat    = s_tvalid && s_tready;
  assign in_ch      = s_tdata[3:0];
  assign in_val     = s_tdata[35:4];
  assign is_last_ch = (32'(cnt) == NUM_CHANNELS - 1);
  assign s1 = (32'(segment) + 1 == NUM_FRAMES) ? '0 : FW'(32'(segment) + 1);
  assign seg_n = {1'b0, segment} + 1'b1;

  assign m_tdata = {1'b0, out_play, out_st, out_val, out_ch};

  // keyframe addressing
  assign ram_we    = (state == S_SAVE);
  assign ram_waddr = AW'(32'(frame_count) * NUM_CHANNELS + 32'(cnt));
  assign ram_raddr = (state == S_RDA) ? AW'(32'(segment) * NUM_CHANNELS + 32'(cnt))
                                      : AW'(32'(s1) * NUM_CHANNELS + 32'(cnt));

  kli_ram #(.WIDTH(32), .DEPTH(Depth)) u_kf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (pose[cnt]),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // shared arithmetic
  assign diff   = {ram_q[31], ram_q} - {kf_a[31], kf_a};
  assign rem_sh = {rem, quo[31]};
  assign rem_ge = (rem_sh >= {1'b0, div_d});
  assign qs     = neg ? (33'd0 - {1'b0, quo}) : {1'b0, quo};
  assign add_sum = {{2{pose[cnt][31]}}, pose[cnt]} + {{2{incr[cnt][31]}}, incr[cnt]}
                 + ((32'(cnt) == DRIFT_CH) ? {{2{drift[31]}}, drift} : 34'd0);
  always_comb begin
    if (add_sum[33:31] == 3'b000 || add_sum[33:31] == 3'b111) begin
      add_sat = add_sum[31:0];
    end else if (add_sum[33]) begin
      add_sat = 32'h8000_0000;
    end else begin
      add_sat = 32'h7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      steps       <= STEPS_RST;
      drift       <= DRIFT_RST;
      frame_count <= '0;
      segment     <= '0;
      step_count  <= '0;
      running     <= 1'b0;
      m_tvalid    <= 1'b0;
      cnt         <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        pose[i] <= '0;
        incr[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STEPS) begin
          steps <= cfg_data[15:0];
        end else begin
          drift <= cfg_data;
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_beat) begin
            cnt       <= '0;
            res_ch    <= 4'd0;
            res_val   <= 32'd0;
            res_st    <= ST_OK;
            from_play <= 1'b0;
            reload    <= 1'b0;
            case (s_tuser)
              CMD_SET: begin
                res_ch <= in_ch;
                if (32'(in_ch) < NUM_CHANNELS) begin
                  pose[in_ch[ChW-1:0]] <= in_val;
                  res_val <= in_val;
                end
                state <= S_ONE;
              end
              CMD_SAVE: begin
                if (32'(frame_count) < NUM_FRAMES) begin
                  state <= S_SAVE;
                end else begin
                  res_st <= ST_FULL;
                  state  <= S_ONE;
                end
              end
              CMD_PLAY: begin
                if (!running && frame_count > FW'(1)) begin
                  segment    <= '0;
                  step_count <= '0;
                  reload     <= 1'b1;
                  from_play  <= 1'b1;
                  state      <= S_RDA;
                end else begin
                  running <= 1'b0;
                  res_st  <= ST_STOP;
                  state   <= S_ONE;
                end
              end
              default: begin
                if (!running) begin
                  state <= S_OUT;
                end else if (step_count >= div_d) begin
                  if (seg_n + 2'd2 > {1'b0, frame_count}) begin
                    segment <= '0;
                    reload  <= 1'b1;
                  end else begin
                    segment <= seg_n[FW-1:0];
                  end
                  step_count <= '0;
                  state      <= S_RDA;
                end else begin
                  state <= S_ADD;
                end
              end
            endcase
          end
        end
        S_SAVE: begin
          if (is_last_ch) begin
            frame_count <= frame_count + 1'b1;
            state       <= S_ONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          // ram_q holds the segment start frame entry now
          kf_a <= ram_q;
          if (reload && 32'(cnt) != KEEP_A && 32'(cnt) != KEEP_B) begin
            pose[cnt] <= ram_q;
          end
          state <= S_GETB;
        end
        S_GETB: begin
          neg   <= diff[32];
          quo   <= diff[32] ? 32'(33'd0 - diff) : diff[31:0];
          rem   <= '0;
          it    <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_ge ? 16'(rem_sh - {1'b0, div_d}) : rem_sh[15:0];
          quo <= {quo[30:0], rem_ge};
          it  <= it + 1'b1;
          if (it == 5'd31) begin
            state <= S_WRI;
          end
        end
        S_WRI: begin
          if (qs[32] == qs[31]) begin
            incr[cnt] <= qs[31:0];
          end else begin
            incr[cnt] <= qs[32] ? 32'h8000_0000 : 32'h7fff_ffff;
          end
          if (is_last_ch) begin
            cnt <= '0;
            if (from_play) begin
              running <= 1'b1;
              state   <= S_ONE;
            end else begin
              state <= S_OUT;
            end
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_RDA;
          end
        end
        S_ADD: begin
          pose[cnt] <= add_sat;
          if (is_last_ch) begin
            cnt        <= '0;
            step_count <= step_count + 1'b1;
            state      <= S_OUT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ONE: begin
          if (out_free) begin
            out_ch   <= res_ch;
            out_val  <= res_val;
            out_st   <= res_st;
            out_play <= running;
            m_tlast  <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_ch   <= 4'(cnt);
            out_val  <= pose[cnt];
            out_st   <= ST_OK;
            out_play <= running;
            m_tlast  <= is_last_ch;
            if (is_last_ch) begin
              cnt   <= '0;
              state <= S_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fc_bound: assert property (@(posedge clk) disable iff (rst)
    32'(frame_count) <= NUM_FRAMES)
    else $error("frame count past table size");

  a_run_frames: assert property (@(posedge clk) disable iff (rst)
    running |-> frame_count > FW'(1))
    else $error("playing with fewer than two frames");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    (running && state == S_IDLE) |-> ({1'b0, segment} + 2'd2 <= {1'b0, frame_count}))
    else $error("segment beyond stored frames");

  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_tuser == CMD_TICK) |=> !s_tready)
    else $error("tick finished with no results");

endmodule

// File: sim/tb_keyframe_linear_interpolator.sv
// Self-checking testbench for keyframe_linear_interpolator: random stream traffic
// with an internal pose/keyframe predictor. Depends on rtl/kli_pkg.sv and the RTL top.
`timescale 1ns / 1ps
module tb_keyframe_linear_interpolator;
  import kli_pkg::*;

  localparam int NFR = 9;
  localparam int NCH = 13;
  localparam int SETTLE = 600;      // worst command runs the divider once per channel
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         ch;
    logic signed [31:0] val;
  } cmd_t;

  typedef struct packed {
    logic [3:0]         ch;
    logic signed [31:0] val;
    logic [1:0]         st;
    logic               playing;
    logic               last;
  } beat_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_data;

  keyframe_linear_interpolator u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted block state
  logic [15:0]        steps_reg;
  logic signed [31:0] drift_reg;
  logic signed [31:0] pose [NCH] = '{default: '0};
  logic signed [31:0] incr [NCH] = '{default: '0};
  logic signed [31:0] kf [NFR][NCH];
  int unsigned        n_frames = 0, seg = 0, step_cnt = 0;
  logic               running = 1'b0;

  cmd_t  cmd_q[$];
  beat_t pose_beats_q[$];
  int    errors = 0;
  bit    no_idle = 0;
  int    hold_seq = 0;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint eff_steps();
    return (steps_reg == 16'd0) ? 1 : longint'(steps_reg);
  endfunction

  function automatic void load_frame0();
    for (int c = 0; c < NCH; c++)
      if (c != KEEP_A && c != KEEP_B) pose[c] = kf[0][c];
  endfunction

  function automatic void calc_incr();
    int s0, s1;
    s0 = seg % NFR;
    s1 = (seg + 1) % NFR;
    for (int c = 0; c < NCH; c++)
      incr[c] = sat32((longint'(kf[s1][c]) - longint'(kf[s0][c])) / eff_steps());
  endfunction

  function automatic void push_beat(logic [3:0] ch, logic signed [31:0] v, logic [1:0] st,
                                    logic lst);
    beat_t b;
    b.ch = ch; b.val = v; b.st = st; b.playing = running; b.last = lst;
    pose_beats_q.push_back(b);
  endfunction

  function automatic void apply_cmd(cmd_t it);
    logic [1:0] st;
    longint s;
    case (it.cmd)
      CMD_SET: begin
        if (it.ch < NCH) begin
          pose[it.ch] = it.val;
          push_beat(it.ch, it.val, ST_OK, 1'b1);
        end else begin
          push_beat(it.ch, 32'sd0, ST_OK, 1'b1);
        end
      end
      CMD_SAVE: begin
        st = ST_FULL;
        if (n_frames < NFR) begin
          for (int c = 0; c < NCH; c++) kf[n_frames][c] = pose[c];
          n_frames++;
          st = ST_OK;
        end
        push_beat(4'd0, 32'sd0, st, 1'b1);
      end
      CMD_PLAY: begin
        if (!running && n_frames > 1) begin
          seg = 0; step_cnt = 0;
          load_frame0();
          calc_incr();
          running = 1'b1;
          st = ST_OK;
        end else begin
          running = 1'b0;
          st = ST_STOP;
        end
        push_beat(4'd0, 32'sd0, st, 1'b1);
      end
      default: begin
        if (running) begin
          if (step_cnt >= eff_steps()) begin
            seg++;
            if (seg + 2 > n_frames) begin
              seg = 0;
              load_frame0();
            end
            step_cnt = 0;
            calc_incr();
          end else begin
            for (int c = 0; c < NCH; c++) begin
              s = longint'(pose[c]) + longint'(incr[c]);
              if (c == DRIFT_CH) s += longint'(drift_reg);
              pose[c] = sat32(s);
            end
            step_cnt = (step_cnt + 1) & 16'hffff;
          end
        end
        for (int c = 0; c < NCH; c++) push_beat(c[3:0], pose[c], ST_OK, c == NCH - 1);
      end
    endcase
  endfunction

  // command driver
  cmd_t cur_cmd;
  int   s_gap = 0;
  always @(posedge clk) begin
    logic nvalid;
    cmd_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nvalid = s_tvalid;
      if (s_tvalid && s_tready) begin
        apply_cmd(cur_cmd);
        nvalid = 1'b0;
        s_gap = no_idle ? 0 : $urandom_range(0, 13);
      end
      if (!(s_tvalid && !s_tready)) begin
        if (s_gap > 0) begin
          s_gap--;
        end else if (cmd_q.size() > 0) begin
          it = cmd_q.pop_front();
          cur_cmd = it;
          s_tdata <= {4'b0, it.val, it.ch};
          s_tuser <= it.cmd;
          nvalid = 1'b1;
        end
      end
      s_tvalid <= nvalid;
    end
  end

  // result monitor
  int m_stall = 0, hold_left = 0, hold_seen = 0;
  always @(posedge clk) begin
    logic nready;
    beat_t want, got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      nready = m_tready;
      if (m_tvalid && m_tready) begin
        got.ch = m_tdata[3:0]; got.val = m_tdata[35:4]; got.st = m_tdata[37:36];
        got.playing = m_tdata[38]; got.last = m_tlast;
        if (pose_beats_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat: %p", got);
        end else begin
          want = pose_beats_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
        m_stall = no_idle ? 0 : $urandom_range(0, 13);
      end
      if (hold_left > 0) begin
        hold_left--;
        nready = 1'b0;
      end else if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = 400;
        nready = 1'b0;
      end else if (m_stall > 0) begin
        m_stall--;
        nready = 1'b0;
      end else begin
        nready = 1'b1;
      end
      m_tready <= nready;
    end
  end

  // watchdog on cycles with no handshake at all
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("keyframe_linear_interpolator regression: fail");
      $finish;
    end
  end

  task automatic push_cmd(logic [1:0] cmd, logic [3:0] ch, logic signed [31:0] v);
    cmd_t it;
    it.cmd = cmd; it.ch = ch; it.val = v;
    cmd_q.push_back(it);
  endtask

  // sample on the falling edge so driver and monitor updates have settled
  task automatic drain();
    do @(negedge clk);
    while (cmd_q.size() != 0 || s_tvalid || pose_beats_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_STEPS) steps_reg = d[15:0];
    else drift_reg = d;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // well-formed playback traffic with some sets, saves, stops and noise
  task automatic random_phase(int n);
    int k;
    if (!running) push_cmd(CMD_PLAY, 4'd0, 32'sd0);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: push_cmd(CMD_SET, 4'($urandom_range(0, 15)), rand_val());
        3, 4:    push_cmd(CMD_SAVE, 4'($urandom_range(0, 15)), $urandom);
        5:       push_cmd(CMD_PLAY, 4'($urandom_range(0, 15)), $urandom);
        6, 7:    push_cmd(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom);
        default: push_cmd(CMD_TICK, 4'($urandom_range(0, 15)), $urandom);
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    steps_reg = STEPS_RST; drift_reg = DRIFT_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: idle tick, refused plays, channel range, saturation extremes
    push_cmd(CMD_TICK, 4'd0, 32'sd0);
    push_cmd(CMD_PLAY, 4'd0, 32'sd0);
    push_cmd(CMD_SET, 4'd0, 32'sh7fffffff);
    push_cmd(CMD_SET, 4'd1, 32'sh80000000);
    push_cmd(CMD_SET, 4'd3, 32'sd5);
    push_cmd(CMD_SET, 4'd4, -32'sd7);
    push_cmd(CMD_SET, 4'd12, $urandom);
    push_cmd(CMD_SET, 4'd13, $urandom);
    push_cmd(CMD_SET, 4'd15, 32'shffffffff);
    push_cmd(CMD_SAVE, 4'd0, 32'sd0);
    push_cmd(CMD_PLAY, 4'd0, 32'sd0);
    push_cmd(CMD_SET, 4'd0, 32'sh80000000);
    push_cmd(CMD_SET, 4'd1, 32'sh7fffffff);
    push_cmd(CMD_SET, 4'd2, 32'sh00012345);
    push_cmd(CMD_SAVE, 4'd0, 32'sd0);
    push_cmd(CMD_PLAY, 4'd0, 32'sd0);
    repeat (4) push_cmd(CMD_TICK, 4'd0, 32'sd0);
    push_cmd(CMD_PLAY, 4'd0, 32'sd0);
    push_cmd(CMD_TICK, 4'd0, 32'sd0);
    drain();

    // single-step segments, drift at its maximum
    write_reg(CFG_STEPS, 32'd1);
    write_reg(CFG_DRIFT, 32'h7fffffff);
    push_cmd(CMD_PLAY, 4'd0, 32'sd0);
    repeat (4) push_cmd(CMD_TICK, 4'd0, 32'sd0);
    drain();

    write_reg(CFG_STEPS, 32'd2);
    write_reg(CFG_DRIFT, 32'h80000000);
    hold_seq <= hold_seq + 1;     // long output stall while commands queue up
    no_idle = 1;
    random_phase(20);
    drain();
    no_idle = 0;

    write_reg(CFG_STEPS, 32'd0);
    write_reg(CFG_DRIFT, 32'd0);
    random_phase(20);
    drain();

    write_reg(CFG_STEPS, 32'd65535);
    write_reg(CFG_DRIFT, $urandom);
    random_phase(15);
    drain();

    write_reg(CFG_STEPS, 32'd3);
    write_reg(CFG_DRIFT, 32'd6554);
    random_phase(20);
    drain();

    write_reg(CFG_STEPS, $urandom_range(1, 5));
    write_reg(CFG_DRIFT, $urandom);
    random_phase(20);
    drain();

    if (errors == 0 && pose_beats_q.size() == 0) begin
      $display("keyframe_linear_interpolator regression: pass");
    end else begin
      $display("keyframe_linear_interpolator regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/kli_pkg.sv
rtl/kli_ram.sv
rtl/keyframe_linear_interpolator.sv
sim/tb_keyframe_linear_interpolator.sv
